FILE: rtl/gsp_pkg.sv
`default_nettype none

package gsp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_BIT_TICKS = 2'd0;
    localparam logic [1:0] CFG_BYTE_GAP_TICKS = 2'd1;
    localparam logic [1:0] CFG_FAIL_THRESHOLD = 2'd2;

    localparam logic [7:0] RST_HALF_BIT_TICKS = 8'd16;
    localparam logic [7:0] RST_BYTE_GAP_TICKS = 8'd25;
    localparam logic [7:0] RST_FAIL_THRESHOLD = 8'd10;

    localparam logic [7:0] CMD_POLL_START = 8'h01;
    localparam logic [7:0] CMD_POLL_READ  = 8'h42;
    localparam logic [7:0] MODE_DIGITAL   = 8'h41;
    localparam logic [7:0] MODE_ANALOG    = 8'h73;

    localparam logic signed [15:0] Q_ONE = 16'sd16384;

    typedef struct packed {
        logic start_req;
        logic miso;
    } t_in;

    typedef struct packed {
        logic               cs_n;
        logic               sclk;
        logic               mosi;
        logic               frame_done;
        logic               connected;
        logic [7:0]         mode_code;
        logic [15:0]        buttons;
        logic [31:0]        sticks;
        logic signed [15:0] throttle;
        logic signed [15:0] steering;
    } t_out;

    // sequencer status toward the top level
    typedef struct packed {
        logic        cs_n;
        logic        sclk;
        logic        mosi;
        logic        frame_done;
        logic        link_up;
        logic [7:0]  mode_byte;
        logic [15:0] button_bits;
        logic [31:0] stick_bytes;
    } t_seq_stat;

    function automatic logic [7:0] command_byte(input logic [7:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 8'd0) b = CMD_POLL_START;
        else if (idx == 8'd1) b = CMD_POLL_READ;
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gsp_scale.sv
`default_nettype none

// Q1.14 of num/127, truncated toward zero, clamped to +-1.
// For |num| <= 128: |num|*16384/127 = 129*|num| + |num|/127.
module gsp_scale (
    input  wire logic signed [8:0]  i_num,
    output logic signed [15:0]      o_q14
);
    logic       neg;
    logic [7:0] mag;
    logic [14:0] q;
    logic [14:0] sat;

    always_comb begin
        neg = i_num[8];
        mag = neg ? 8'(-i_num) : i_num[7:0];
        q   = (15'(mag) << 7) + 15'(mag) + ((mag >= 8'd127) ? 15'd1 : 15'd0);
        sat = (q > 15'(gsp_pkg::Q_ONE)) ? 15'(gsp_pkg::Q_ONE) : q;
        o_q14 = neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end
endmodule

`default_nettype wire

FILE: rtl/gsp_seq.sv
`default_nettype none

module gsp_seq #(
    parameter int FRAME_BYTES = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire gsp_pkg::t_in          i_in,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [7:0]            i_cfg_data,
    output gsp_pkg::t_seq_stat         o_stat
);
    localparam int BW = $clog2(FRAME_BYTES);
    localparam logic [BW-1:0] LAST_BYTE = BW'(FRAME_BYTES - 1);

    logic [7:0] r_half, r_gap, r_thr;

    gsp_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_tick, n_tick;
    logic [2:0]    r_bit, n_bit;
    logic [BW-1:0] r_byte, n_byte;
    logic [7:0]    r_shift, n_shift;
    logic [7:0]    r_stg_mode, n_stg_mode;
    logic [15:0]   r_stg_btn, n_stg_btn;
    logic [31:0]   r_stg_stk, n_stg_stk;
    logic [7:0]    r_mode, n_mode;
    logic [15:0]   r_btn, n_btn;
    logic [31:0]   r_stk, n_stk;
    logic [7:0]    r_fail, n_fail;
    logic          r_link, n_link;

    logic [7:0] tick_inc;
    logic [7:0] half;
    logic       end_byte;
    logic       done;
    logic [7:0] cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= gsp_pkg::RST_HALF_BIT_TICKS;
            r_gap  <= gsp_pkg::RST_BYTE_GAP_TICKS;
            r_thr  <= gsp_pkg::RST_FAIL_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gsp_pkg::CFG_HALF_BIT_TICKS: r_half <= i_cfg_data;
                gsp_pkg::CFG_BYTE_GAP_TICKS: r_gap  <= i_cfg_data;
                gsp_pkg::CFG_FAIL_THRESHOLD: r_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_byte     = r_byte;
        n_shift    = r_shift;
        n_stg_mode = r_stg_mode;
        n_stg_btn  = r_stg_btn;
        n_stg_stk  = r_stg_stk;
        n_mode     = r_mode;
        n_btn      = r_btn;
        n_stk      = r_stk;
        n_fail     = r_fail;
        n_link     = r_link;
        end_byte   = 1'b0;
        done       = 1'b0;
        tick_inc   = r_tick + 8'd1;
        half       = (r_half == 8'd0) ? 8'd1 : r_half;

        unique case (r_phase)
            gsp_pkg::PH_IDLE: begin
                if (i_in.start_req) begin
                    n_phase = gsp_pkg::PH_LOW;
                    n_tick  = 8'd0;
                    n_bit   = 3'd0;
                    n_byte  = '0;
                    n_shift = 8'd0;
                end
            end
            gsp_pkg::PH_LOW: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    if (i_in.miso) n_shift = r_shift | (8'd1 << r_bit);
                    n_tick  = 8'd0;
                    n_phase = gsp_pkg::PH_HIGH;
                end
            end
            gsp_pkg::PH_HIGH: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    n_tick = 8'd0;
                    if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = gsp_pkg::PH_LOW;
                    end else if (r_gap != 8'd0) begin
                        n_phase = gsp_pkg::PH_GAP;
                    end else begin
                        end_byte = 1'b1;
                    end
                end
            end
            gsp_pkg::PH_GAP: begin
                n_tick = tick_inc;
                if (tick_inc >= r_gap) end_byte = 1'b1;
            end
            default: ;
        endcase

        if (end_byte) begin
            if (r_byte == BW'(1)) n_stg_mode = r_shift;
            else if (r_byte == BW'(3)) n_stg_btn[7:0] = ~r_shift;
            else if (r_byte == BW'(4)) n_stg_btn[15:8] = ~r_shift;
            else if (r_byte == BW'(5)) n_stg_stk[7:0] = r_shift;
            else if (r_byte == BW'(6)) n_stg_stk[15:8] = r_shift;
            else if (r_byte == BW'(7)) n_stg_stk[23:16] = r_shift;
            else if (r_byte == BW'(8)) n_stg_stk[31:24] = r_shift;

            n_tick = 8'd0;
            n_bit  = 3'd0;
            if (r_byte >= LAST_BYTE) begin
                done    = 1'b1;
                n_mode  = n_stg_mode;
                n_btn   = n_stg_btn;
                n_stk   = n_stg_stk;
                n_phase = gsp_pkg::PH_IDLE;
                n_byte  = '0;
                if (n_stg_mode == gsp_pkg::MODE_DIGITAL ||
                    n_stg_mode == gsp_pkg::MODE_ANALOG) begin
                    n_fail = 8'd0;
                    n_link = 1'b1;
                end else begin
                    if (r_fail != 8'hFF) n_fail = r_fail + 8'd1;
                    if (n_fail >= r_thr) n_link = 1'b0;
                end
            end else begin
                n_byte  = r_byte + BW'(1);
                n_shift = 8'd0;
                n_phase = gsp_pkg::PH_LOW;
            end
        end
    end

    // pin levels come from the state held during this tick
    always_comb begin
        cmd                = gsp_pkg::command_byte(8'(r_byte));
        o_stat.cs_n        = (r_phase == gsp_pkg::PH_IDLE);
        o_stat.sclk        = (r_phase != gsp_pkg::PH_LOW);
        o_stat.mosi        = (r_phase == gsp_pkg::PH_IDLE) ? 1'b1 : cmd[r_bit];
        o_stat.frame_done  = done;
        o_stat.link_up     = n_link;
        o_stat.mode_byte   = n_mode;
        o_stat.button_bits = n_btn;
        o_stat.stick_bytes = n_stk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= gsp_pkg::PH_IDLE;
            r_tick     <= 8'd0;
            r_bit      <= 3'd0;
            r_byte     <= '0;
            r_shift    <= 8'd0;
            r_stg_mode <= 8'd0;
            r_stg_btn  <= 16'd0;
            r_stg_stk  <= 32'd0;
            r_mode     <= 8'd0;
            r_btn      <= 16'd0;
            r_stk      <= 32'd0;
            r_fail     <= 8'd0;
            r_link     <= 1'b0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_byte     <= n_byte;
            r_shift    <= n_shift;
            r_stg_mode <= n_stg_mode;
            r_stg_btn  <= n_stg_btn;
            r_stg_stk  <= n_stg_stk;
            r_mode     <= n_mode;
            r_btn      <= n_btn;
            r_stk      <= n_stk;
            r_fail     <= n_fail;
            r_link     <= n_link;
        end
    end
endmodule

`default_nettype wire

FILE: rtl/gamepad_serial_poller.sv
`default_nettype none

// Tick-driven poller for a PS2-style gamepad. Every input beat is one timing
// tick (start request plus the sampled data line) and produces exactly one
// output beat: the pin levels held during that tick (cs_n, sclk, mosi) and
// the decoded pad state after it (mode, buttons, sticks, link, Q1.14
// throttle and steering). A frame of FRAME_BYTES bytes (0x01, 0x42, zeros)
// is clocked LSB first; the reply is published with frame_done=1 on the
// tick the frame ends. Throughput is one tick per clock: the whole update
// runs between the sequencer registers and one output register, and a new
// tick is taken whenever that register is empty or being drained.
// Configuration writes should happen with the sequencer idle.
module gamepad_serial_poller #(
    parameter int FRAME_BYTES = 9
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // tick input
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire gsp_pkg::t_in   i_in_data,
    // result output
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output gsp_pkg::t_out       o_out_data,
    // configuration writes
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_data
);
    gsp_pkg::t_seq_stat stat;
    gsp_pkg::t_out      n_out;
    gsp_pkg::t_out      r_out;
    logic               r_out_valid;
    logic               in_accept;
    logic signed [8:0]  thr_num;
    logic signed [8:0]  str_num;
    logic signed [15:0] thr_q14;
    logic signed [15:0] str_q14;

    // stall only while a held beat is blocked downstream
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    gsp_seq #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (in_accept),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat)
    );

    // left stick: y in the top byte, x below it
    assign thr_num = 9'sd127 - $signed({1'b0, stat.stick_bytes[31:24]});
    assign str_num = $signed({1'b0, stat.stick_bytes[23:16]}) - 9'sd128;

    gsp_scale u_thr (
        .i_num (thr_num),
        .o_q14 (thr_q14)
    );

    gsp_scale u_str (
        .i_num (str_num),
        .o_q14 (str_q14)
    );

    always_comb begin
        n_out.cs_n       = stat.cs_n;
        n_out.sclk       = stat.sclk;
        n_out.mosi       = stat.mosi;
        n_out.frame_done = stat.frame_done;
        n_out.connected  = stat.link_up;
        n_out.mode_code  = stat.link_up ? stat.mode_byte : gsp_pkg::MODE_DIGITAL;
        n_out.buttons    = stat.button_bits;
        n_out.sticks     = stat.stick_bytes;
        // offline link reads as centered controls
        n_out.throttle   = stat.link_up ? thr_q14 : 16'sd0;
        n_out.steering   = stat.link_up ? str_q14 : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

`default_nettype wire

FILE: rtl/gsp_chk.sv
`default_nettype none

module gsp_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_out_valid,
    input wire logic          i_out_stall,
    input wire gsp_pkg::t_out i_out_data
);
    // a frame can only finish on a tick that ran with chip select low
    a_done_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.frame_done |-> !i_out_data.cs_n)
        else $error("frame_done with chip select high");

    a_offline_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.connected |->
            i_out_data.mode_code == gsp_pkg::MODE_DIGITAL &&
            i_out_data.throttle == 16'sd0 && i_out_data.steering == 16'sd0)
        else $error("offline beat carries live values");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.cs_n |-> i_out_data.sclk && i_out_data.mosi)
        else $error("bus not idle with chip select high");

    a_q14_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_out_data.throttle <= gsp_pkg::Q_ONE &&
            i_out_data.throttle >= -gsp_pkg::Q_ONE &&
            i_out_data.steering <= gsp_pkg::Q_ONE &&
            i_out_data.steering >= -gsp_pkg::Q_ONE)
        else $error("Q1.14 output out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output beat changed");
endmodule

bind gamepad_serial_poller gsp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
